FILE: rtl/core/pgm_pkg.sv
// ----------------------------------------------------------------------------
// pgm_pkg
// Shared types and constants for the PCM gain, clip and level meter block.
// ----------------------------------------------------------------------------
package pgm_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int SLOT_SHIFT  = 16;
   localparam int DIV_STEPS   = 64;
   localparam int SQRT_STEPS  = 32;
   localparam int ITER_W      = $clog2(DIV_STEPS);

   localparam logic signed [24:0] PCM_MAX = 25'sd32767;
   localparam logic signed [24:0] PCM_MIN = -25'sd32768;

   localparam logic [7:0]  GAIN_RESET = 8'd1;
   localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

   localparam logic ACT_SAMPLE  = 1'b0;
   localparam logic ACT_READOUT = 1'b1;

   typedef struct packed {
      logic               action;
      logic signed [31:0] raw_slot;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pcm_sample;
      logic               clipped;
      logic               meter_empty;
      logic        [15:0] rms_level;
      logic        [31:0] clip_total;
      logic        [31:0] sample_total;
   } rsp_type;

   typedef struct packed {
      logic               action;
      logic signed [15:0] sample;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } back_state_type;

endpackage

FILE: rtl/core/pgm_front.sv
// ----------------------------------------------------------------------------
// pgm_front
// Accepts request transactions, keeps the top 16 bits of the slot and queues
// the classified command for the back end.
// ----------------------------------------------------------------------------
module pgm_front import pgm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  req_type      req_data,
   output cmd_head_type head,
   input  logic         cmd_pop
);

   cmd_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;
   cmd_type          cmd_new;

   assign req_full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push  = req_push && !req_full;
   assign do_pop   = cmd_pop && (count_ff != '0);

   always_comb begin
      cmd_new.action = req_data.action;
      cmd_new.sample = req_data.raw_slot[31:SLOT_SHIFT];
   end

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   always_comb begin
      head.valid = (count_ff != '0);
      head.cmd   = mem_ff[rd_ptr_ff];
   end

endmodule

FILE: rtl/core/pgm_back.sv
// ----------------------------------------------------------------------------
// pgm_back
// Gain, saturation and accumulation of samples; readout through a bit-serial
// divider and an iterative integer square root.
// ----------------------------------------------------------------------------
module pgm_back import pgm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       gain,
   input  cmd_head_type     head,
   output logic             cmd_pop,
   input  logic [CNT_W-1:0] rsp_count,
   output logic             rsp_push,
   output rsp_type          rsp_entry
);

   back_state_type    state_ff, state_in;

   logic [63:0]       sum_ff, sum_in;
   logic [31:0]       samples_ff, samples_in;
   logic [31:0]       clips_ff, clips_in;

   logic              stage_valid_ff, stage_valid_in;
   logic signed [15:0] stage_p_ff;
   logic              stage_clip_ff;

   logic [31:0]       rem_ff, rem_in;
   logic [63:0]       quo_ff, quo_in;
   logic [31:0]       divisor_ff, divisor_in;
   logic [31:0]       clip_hold_ff, clip_hold_in;
   logic [63:0]       x_ff, x_in;
   logic [63:0]       res_ff, res_in;
   logic [63:0]       bit_ff, bit_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   logic [CNT_W-1:0]  inflight;
   logic              space;
   logic              issue_sample, issue_readout, readout_empty;

   logic signed [24:0] prod;
   logic signed [15:0] p_sat;
   logic               clip_now;
   logic signed [31:0] sq_signed;
   logic        [64:0] sum_add;

   logic [32:0]       trial;
   logic              trial_ge;
   logic [63:0]       root_try;
   logic              root_ge;

   assign inflight = rsp_count + CNT_W'(stage_valid_ff);
   assign space    = (inflight < CNT_W'(QUEUE_DEPTH));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (issue_readout && !readout_empty) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (iter_ff == '0) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (iter_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // control outputs
   always_comb begin
      issue_sample  = 1'b0;
      issue_readout = 1'b0;
      rsp_push      = 1'b0;
      rsp_entry     = '0;
      case (state_ff)
         ST_RUN: begin
            if (head.valid && space) begin
               if (head.cmd.action == ACT_SAMPLE) begin
                  issue_sample = 1'b1;
               end else if (!stage_valid_ff) begin
                  issue_readout = 1'b1;
               end
            end
            if (stage_valid_ff) begin
               rsp_push             = 1'b1;
               rsp_entry.pcm_sample = stage_p_ff;
               rsp_entry.clipped    = stage_clip_ff;
            end else if (issue_readout && readout_empty) begin
               rsp_push              = 1'b1;
               rsp_entry.meter_empty = 1'b1;
            end
         end
         ST_DONE: begin
            rsp_push               = 1'b1;
            rsp_entry.rms_level    = res_ff[15:0];
            rsp_entry.clip_total   = clip_hold_ff;
            rsp_entry.sample_total = divisor_ff;
         end
         default: begin
         end
      endcase
   end

   assign cmd_pop       = issue_sample || issue_readout;
   assign readout_empty = (samples_ff == '0);

   // gain and saturation
   always_comb begin
      prod     = $signed(head.cmd.sample) * $signed({1'b0, gain});
      clip_now = 1'b0;
      p_sat    = prod[15:0];
      if (prod > PCM_MAX) begin
         p_sat    = PCM_MAX[15:0];
         clip_now = 1'b1;
      end else if (prod < PCM_MIN) begin
         p_sat    = PCM_MIN[15:0];
         clip_now = 1'b1;
      end
   end

   // square and accumulate
   always_comb begin
      sq_signed  = stage_p_ff * stage_p_ff;
      sum_add    = {1'b0, sum_ff} + {33'd0, sq_signed};
      sum_in     = sum_ff;
      samples_in = samples_ff;
      clips_in   = clips_ff;
      if (issue_readout) begin
         sum_in     = '0;
         samples_in = '0;
         clips_in   = '0;
      end else if (stage_valid_ff) begin
         sum_in = sum_add[64] ? '1 : sum_add[63:0];
         if (samples_ff != COUNT_MAX) begin
            samples_in = samples_ff + 32'd1;
         end
         if (stage_clip_ff && clips_ff != COUNT_MAX) begin
            clips_in = clips_ff + 32'd1;
         end
      end
   end

   assign stage_valid_in = issue_sample;

   // division and root
   always_comb begin
      trial    = {rem_ff, quo_ff[63]};
      trial_ge = (trial >= {1'b0, divisor_ff});
      root_try = res_ff + bit_ff;
      root_ge  = (x_ff >= root_try);

      rem_in       = rem_ff;
      quo_in       = quo_ff;
      divisor_in   = divisor_ff;
      clip_hold_in = clip_hold_ff;
      x_in         = x_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      iter_in      = iter_ff;

      case (state_ff)
         ST_RUN: begin
            if (issue_readout) begin
               rem_in       = '0;
               quo_in       = sum_ff;
               divisor_in   = samples_ff;
               clip_hold_in = clips_ff;
               iter_in      = ITER_W'(DIV_STEPS - 1);
            end
         end
         ST_DIV: begin
            rem_in = trial_ge ? 32'(trial - {1'b0, divisor_ff}) : trial[31:0];
            quo_in = {quo_ff[62:0], trial_ge};
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == '0) begin
               x_in    = {quo_ff[62:0], trial_ge};
               res_in  = '0;
               bit_in  = 64'd1 << 62;
               iter_in = ITER_W'(SQRT_STEPS - 1);
            end
         end
         ST_SQRT: begin
            if (root_ge) begin
               x_in   = x_ff - root_try;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            iter_in = iter_ff - ITER_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_RUN;
         stage_valid_ff <= 1'b0;
         sum_ff         <= '0;
         samples_ff     <= '0;
         clips_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         stage_valid_ff <= stage_valid_in;
         sum_ff         <= sum_in;
         samples_ff     <= samples_in;
         clips_ff       <= clips_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_sample) begin
         stage_p_ff    <= p_sat;
         stage_clip_ff <= clip_now;
      end
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      divisor_ff   <= divisor_in;
      clip_hold_ff <= clip_hold_in;
      x_ff         <= x_in;
      res_ff       <= res_in;
      bit_ff       <= bit_in;
      iter_ff      <= iter_in;
   end

endmodule

FILE: rtl/core/pgm_rsp_queue.sv
// ----------------------------------------------------------------------------
// pgm_rsp_queue
// Result queue toward the consumer; reports its fill level for flow control.
// ----------------------------------------------------------------------------
module pgm_rsp_queue import pgm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             rsp_push,
   input  rsp_type          rsp_entry,
   output logic [CNT_W-1:0] rsp_count,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_data
);

   rsp_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign rsp_empty = (count_ff == '0);
   assign rsp_count = count_ff;
   assign do_pop    = rsp_pop && !rsp_empty;
   assign rsp_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = rsp_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(rsp_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         mem_ff[wr_ptr_ff] <= rsp_entry;
      end
   end

endmodule

FILE: rtl/core/pcm_gain_clip_level_meter_top.sv
// Sample transaction: the gained sample is registered in the stage register,
// then pushed into the result queue. Samples sustain one per cycle through the
// gain/saturate and square stages while the result queue has room. Readout:
// 64 division steps plus 32 square root steps, during which the command queue
// holds transactions. Synchronous active-high reset empties both queues, clears
// the accumulators and sets the gain to 1.
// ----------------------------------------------------------------------------
// pcm_gain_clip_level_meter_top
// Gained, saturated PCM from microphone slots with an RMS level meter.
// ----------------------------------------------------------------------------
module pcm_gain_clip_level_meter_top import pgm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_data,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   logic [7:0]       gain_ff, gain_in;
   cmd_head_type     head;
   logic             cmd_pop;
   logic [CNT_W-1:0] rsp_count;
   logic             rsp_push;
   rsp_type          rsp_entry;

   assign gain_in = csr_we ? csr_wdata : gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   pgm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .head     (head),
      .cmd_pop  (cmd_pop)
   );

   pgm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .gain      (gain_ff),
      .head      (head),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_entry (rsp_entry)
   );

   pgm_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .rsp_push  (rsp_push),
      .rsp_entry (rsp_entry),
      .rsp_count (rsp_count),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: verif/tb_pcm_gain_clip_level_meter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcm_gain_clip_level_meter_top
// Self-checking bench for the PCM gain, clip and level meter block.
// A behavioral model tracks the gain, the sum of squares and both counters,
// and predicts every response at the moment its request is accepted.
// Directed transactions hit the slot and gain extremes, clipping at both
// rails, full-scale RMS, zero gain and empty readouts. Random streams then
// run under several gain settings with bursty stalls on both queues, after
// one long response hold that backs up the input queue.
// ----------------------------------------------------------------------------
module tb_pcm_gain_clip_level_meter_top;
   import pgm_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 120;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_push  = 1'b0;
   logic       req_full;
   req_type    req_data  = '0;
   logic       rsp_empty;
   logic       rsp_pop   = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we    = 1'b0;
   logic [7:0] csr_wdata = '0;

   // model state
   logic [7:0]  gain_model   = GAIN_RESET;
   logic [63:0] energy_sum   = '0;
   logic [31:0] sample_tally = '0;
   logic [31:0] clip_tally   = '0;

   rsp_type expected_meter_q[$];

   bit quiet     = 1'b0;
   bit long_hold = 1'b0;
   int held_cycles = 0;
   int pop_stall   = 0;
   int idle_cycles = 0;
   int fail_count  = 0;
   int samples_sent   = 0;
   int readouts_sent  = 0;
   int results_seen   = 0;
   int gain_settings  = 0;

   always #5 clock = ~clock;

   pcm_gain_clip_level_meter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   function automatic logic [31:0] int_root(input logic [63:0] v);
      logic [31:0] r;
      logic [31:0] trial;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = r | (32'd1 << b);
         if ({32'd0, trial} * {32'd0, trial} <= v) r = trial;
      end
      return r;
   endfunction

   function automatic rsp_type meter_step(input req_type t);
      rsp_type            r;
      logic signed [15:0] top;
      int                 level;
      logic [63:0]        square;
      logic [63:0]        mean;
      logic [31:0]        root;
      r = '0;
      if (t.action == ACT_SAMPLE) begin
         top   = t.raw_slot[31:16];
         level = int'(top) * int'(gain_model);
         if (level > PCM_MAX) begin
            level     = int'(PCM_MAX);
            r.clipped = 1'b1;
         end else if (level < PCM_MIN) begin
            level     = int'(PCM_MIN);
            r.clipped = 1'b1;
         end
         r.pcm_sample = level[15:0];
         if (r.clipped && clip_tally != COUNT_MAX) clip_tally++;
         square = 64'(level * level);
         if (energy_sum > ~64'd0 - square) energy_sum = '1;
         else energy_sum += square;
         if (sample_tally != COUNT_MAX) sample_tally++;
      end else begin
         if (sample_tally == 0) begin
            r.meter_empty = 1'b1;
         end else begin
            mean           = energy_sum / {32'd0, sample_tally};
            root           = int_root(mean);
            r.rms_level    = root[15:0];
            r.clip_total   = clip_tally;
            r.sample_total = sample_tally;
         end
         energy_sum   = '0;
         sample_tally = '0;
         clip_tally   = '0;
      end
      return r;
   endfunction

   function automatic void check_meter(input rsp_type got);
      rsp_type exp;
      results_seen++;
      if (expected_meter_q.size() == 0) begin
         $error("unexpected response transaction: pcm_sample %0d rms_level %0d",
                got.pcm_sample, got.rms_level);
         fail_count++;
         return;
      end
      exp = expected_meter_q.pop_front();
      if (got.pcm_sample !== exp.pcm_sample) begin
         $error("pcm_sample: expected %0d, actual %0d", exp.pcm_sample, got.pcm_sample);
         fail_count++;
      end
      if (got.clipped !== exp.clipped) begin
         $error("clipped: expected %0d, actual %0d", exp.clipped, got.clipped);
         fail_count++;
      end
      if (got.meter_empty !== exp.meter_empty) begin
         $error("meter_empty: expected %0d, actual %0d", exp.meter_empty, got.meter_empty);
         fail_count++;
      end
      if (got.rms_level !== exp.rms_level) begin
         $error("rms_level: expected %0d, actual %0d", exp.rms_level, got.rms_level);
         fail_count++;
      end
      if (got.clip_total !== exp.clip_total) begin
         $error("clip_total: expected %0d, actual %0d", exp.clip_total, got.clip_total);
         fail_count++;
      end
      if (got.sample_total !== exp.sample_total) begin
         $error("sample_total: expected %0d, actual %0d",
                exp.sample_total, got.sample_total);
         fail_count++;
      end
   endfunction

   // response side: checks, random stall bursts, long hold on request
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) check_meter(rsp_data);
      if (long_hold && held_cycles < LONG_HOLD) begin
         held_cycles <= held_cycles + 1;
         rsp_pop     <= 1'b0;
      end else begin
         if (!long_hold) held_cycles <= 0;
         if (pop_stall > 0) begin
            pop_stall <= pop_stall - 1;
            rsp_pop   <= 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            pop_stall <= $urandom_range(0, 16);
            rsp_pop   <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // leaves req_push high unless it inserts a random idle gap; the caller's next step either sends or lowers it
   task automatic send_transaction(input req_type t);
      req_data <= t;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_meter_q.push_back(meter_step(t));
      if (t.action == ACT_SAMPLE) samples_sent++;
      else readouts_sent++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic sample_item(input logic [31:0] slot);
      req_type t;
      t.action   = ACT_SAMPLE;
      t.raw_slot = slot;
      send_transaction(t);
   endtask

   task automatic readout_item();
      req_type t;
      t.action   = ACT_READOUT;
      t.raw_slot = $urandom;
      send_transaction(t);
   endtask

   task automatic settle_meter();
      req_push <= 1'b0;
      while (expected_meter_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_gain(input logic [7:0] g);
      csr_wdata <= g;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we     <= 1'b0;
      gain_model  = g;
      gain_settings++;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_slot();
      logic [15:0] top;
      case ($urandom_range(0, 4))
         0: top = 16'($urandom);
         1: top = 16'($urandom_range(0, 511) - 256);
         2: top = 16'($urandom_range(0, 8191) - 4096);
         3: begin
            case ($urandom_range(0, 3))
               0: top = 16'h7FFF;
               1: top = 16'h8000;
               2: top = 16'hFFFF;
               default: top = 16'h0000;
            endcase
         end
         default: top = 16'($urandom_range(0, 1023) - 512);
      endcase
      return {top, 16'($urandom)};
   endfunction

   task automatic test_empty_readout();
      readout_item();
      settle_meter();
   endtask

   // gain still at its reset value here
   task automatic test_unity_gain();
      sample_item(32'h7FFF_FFFF);
      sample_item(32'h8000_0000);
      sample_item(32'hFFFF_FFFF);
      sample_item(32'h0000_FFFF);
      sample_item(32'h0001_0000);
      readout_item();
      settle_meter();
   endtask

   task automatic test_gain_clipping();
      set_gain(8'd255);
      sample_item(32'h7FFF_0000);
      sample_item(32'h8000_0000);
      sample_item(32'h0080_0000);
      sample_item(32'h0081_0000);
      sample_item(32'hFF7F_0000);
      sample_item(32'hFF80_0000);
      readout_item();
      settle_meter();
   endtask

   task automatic test_full_scale_rms();
      set_gain(8'd1);
      repeat (3) sample_item(32'h8000_0000);
      readout_item();
      settle_meter();
   endtask

   task automatic test_zero_gain();
      set_gain(8'd0);
      sample_item(32'h7FFF_FFFF);
      sample_item(32'h8000_0000);
      readout_item();
      readout_item();
      settle_meter();
   endtask

   task automatic test_queue_backpressure();
      set_gain(8'd40);
      quiet     <= 1'b1;
      long_hold <= 1'b1;
      repeat (24) sample_item(random_slot());
      readout_item();
      repeat (10) sample_item(random_slot());
      long_hold <= 1'b0;
      quiet     <= 1'b0;
      settle_meter();
   endtask

   task automatic test_random_stream(input logic [7:0] g, input int count,
                                     input int readout_odds, input bit no_idle);
      set_gain(g);
      quiet <= no_idle;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, readout_odds - 1) == 0) readout_item();
         else sample_item(random_slot());
      end
      settle_meter();
      quiet <= 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_readout();
      test_unity_gain();
      test_gain_clipping();
      test_full_scale_rms();
      test_zero_gain();
      test_queue_backpressure();

      test_random_stream(8'd255, 180, 16, 1'b0);
      test_random_stream(8'd0, 180, 12, 1'b0);
      test_random_stream(8'd1, 180, 20, 1'b0);
      test_random_stream(8'($urandom_range(2, 254)), 180, 16, 1'b1);
      test_random_stream(8'd128, 180, 8, 1'b0);
      test_random_stream(8'($urandom_range(2, 254)), 180, 24, 1'b0);
      test_random_stream(8'($urandom_range(0, 255)), 200, 16, 1'b1);

      req_push <= 1'b0;
      while (expected_meter_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d sample and %0d readout transactions over %0d gain writes.",
               samples_sent, readouts_sent, gain_settings);
      $display("Checked %0d responses, including clipping, empty and full-scale readouts.",
               results_seen);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
